// File: design/timed_window_stats_cascade_unit_defines.svh
// Assertion helpers for the checker file.
`ifndef TIMED_WINDOW_STATS_CASCADE_UNIT_DEFINES_SVH
`define TIMED_WINDOW_STATS_CASCADE_UNIT_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define TWSC_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("twsc: assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define TWSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twsc: assertion failed");

`endif

// File: design/twsc_pkg.sv
`default_nettype none
package twsc_pkg;

    // Field widths
    localparam int VAL_W     = 18;
    localparam int SQV_W     = 2 * VAL_W;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int SOD_W     = 17;
    localparam int DIFF_W    = 19;
    localparam int LIMIT_W   = 17;
    localparam int BND_W     = 6;
    localparam int IDX_W     = 2;
    localparam int CNT_OUT_W = 11;
    localparam int LEVEL_W   = 2;
    localparam int STEP_W    = 3;

    // Configuration register indexes and reset values
    localparam logic [IDX_W-1:0]   REG_LIMIT      = 2'd0;
    localparam logic [IDX_W-1:0]   REG_BOUNDARY   = 2'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 17'd600;
    localparam logic [BND_W-1:0]   BOUNDARY_RESET = 6'd10;

    // Time constants
    localparam logic [SOD_W-1:0]  SEC_PER_HOUR = 17'd3600;
    localparam logic [SOD_W-1:0]  SEC_PER_MIN  = 17'd60;
    localparam logic [DIFF_W-1:0] DAY_SECONDS  = 19'(24 * 3600);
    localparam logic [DIFF_W-1:0] TWO_DAYS     = 19'(2 * 24 * 3600);

    // Result levels
    localparam logic [LEVEL_W-1:0] LVL_WINDOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_HOUR   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_DAY    = 2'd2;

    typedef enum logic [1:0] {
        ARITH_MUL  = 2'd0,
        ARITH_DIV  = 2'd1,
        ARITH_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    // One classified sample between front and back
    typedef struct packed {
        logic [VAL_W-1:0]  sample;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [SOD_W-1:0]  now_s;
        logic [SQV_W-1:0]  sq;
        logic              boundary_hit;
    } item_t;

    // One statistics beat
    typedef struct packed {
        logic [LEVEL_W-1:0]   level;
        logic [VAL_W-1:0]     mean;
        logic [VAL_W-1:0]     maxv;
        logic [VAL_W-1:0]     minv;
        logic [VAL_W-1:0]     sd;
        logic [CNT_OUT_W-1:0] count;
        logic [HOUR_W-1:0]    hour;
        logic [MIN_W-1:0]     minute;
        logic [SEC_W-1:0]     second;
        logic                 last;
    } result_t;

endpackage
`default_nettype wire

// File: design/twsc_fifo.sv
`default_nettype none
module twsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   rd_ptr_reg;

    // Compare pointers with a wrap bit
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W])
                && (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign dout  = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= din;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: design/twsc_front.sv
`default_nettype none
module twsc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [twsc_pkg::VAL_W-1:0]     sample,
    input  logic [twsc_pkg::HOUR_W-1:0]    hour_of_day,
    input  logic [twsc_pkg::MIN_W-1:0]     minute_of_hour,
    input  logic [twsc_pkg::SEC_W-1:0]     second_of_minute,
    output logic                           full,
    input  logic [twsc_pkg::BND_W-1:0]     boundary_minutes,
    output twsc_pkg::item_t                item,
    output logic                           item_valid,
    input  logic                           item_ready
);
    import twsc_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MOD  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    item_t              item_reg, item_next;
    logic [BND_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [BND_W:0]     rem_sh;
    logic [BND_W:0]     rem_x;

    assign item = item_reg;

    // One restoring step of minute modulo boundary_minutes, MSB first
    always_comb
    begin
        rem_sh = {rem_reg, item_reg.minute[STEP_W'(MIN_W - 1) - step_reg]};
        if (rem_sh >= {1'b0, boundary_minutes})
        begin
            rem_x = rem_sh - {1'b0, boundary_minutes};
        end
        else
        begin
            rem_x = rem_sh;
        end
    end

    // Sequence: take sample, reduce minute, hand off
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        full       = 1'b1;
        item_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    item_next.sample       = sample;
                    item_next.hour         = hour_of_day;
                    item_next.minute       = minute_of_hour;
                    item_next.second       = second_of_minute;
                    item_next.now_s        = SOD_W'(hour_of_day) * SEC_PER_HOUR
                                           + SOD_W'(minute_of_hour) * SEC_PER_MIN
                                           + SOD_W'(second_of_minute);
                    item_next.sq           = SQV_W'(sample) * SQV_W'(sample);
                    item_next.boundary_hit = 1'b0;
                    rem_next               = '0;
                    step_next              = '0;
                    state_next             = F_MOD;
                end
            end
            F_MOD:
            begin
                rem_next  = rem_x[BND_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MIN_W - 1))
                begin
                    item_next.boundary_hit = (boundary_minutes != '0)
                                          && (rem_x == '0)
                                          && (item_reg.second == '0);
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                item_valid = 1'b1;
                if (item_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rem_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end
endmodule
`default_nettype wire

// File: design/twsc_arith.sv
`default_nettype none
module twsc_arith #(
    parameter int AW = 58
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  twsc_pkg::arith_req_t   req,
    input  logic [AW-1:0]          a,
    input  logic [AW-1:0]          b,
    output twsc_pkg::arith_stat_t  stat,
    output logic [AW-1:0]          y
);
    import twsc_pkg::*;

    localparam int CW = $clog2(AW + 1);

    // r0: accumulator / remainder / radicand, r1: multiplicand / quotient / root,
    // r2: multiplier / divisor / root bit
    logic [AW-1:0] r0_reg, r0_next;
    logic [AW-1:0] r1_reg, r1_next;
    logic [AW-1:0] r2_reg, r2_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    arith_op_t     op_reg, op_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [AW:0]   rem_sh;
    logic [AW-1:0] root_try;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign y         = (op_reg == ARITH_MUL) ? r0_reg : r1_reg;

    assign rem_sh   = {r0_reg, r1_reg[AW-1]};
    assign root_try = r1_reg + r2_reg;

    // One bit of multiply or divide, or one root digit, per cycle
    always_comb
    begin
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                op_next   = req.op;
                busy_next = 1'b1;
                unique case (req.op)
                    ARITH_MUL:
                    begin
                        r0_next  = '0;
                        r1_next  = a;
                        r2_next  = b;
                        cnt_next = CW'(AW);
                    end
                    ARITH_DIV:
                    begin
                        r0_next  = '0;
                        r1_next  = a;
                        r2_next  = b;
                        cnt_next = CW'(AW);
                    end
                    ARITH_SQRT:
                    begin
                        r0_next  = a;
                        r1_next  = '0;
                        r2_next  = AW'(1) << (AW - 2);
                        cnt_next = CW'(AW / 2);
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            unique case (op_reg)
                ARITH_MUL:
                begin
                    if (r2_reg[0])
                    begin
                        r0_next = r0_reg + r1_reg;
                    end
                    r1_next = r1_reg << 1;
                    r2_next = r2_reg >> 1;
                end
                ARITH_DIV:
                begin
                    if (rem_sh >= {1'b0, r2_reg})
                    begin
                        r0_next = AW'(rem_sh - {1'b0, r2_reg});
                        r1_next = {r1_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        r0_next = rem_sh[AW-1:0];
                        r1_next = {r1_reg[AW-2:0], 1'b0};
                    end
                end
                ARITH_SQRT:
                begin
                    if (r0_reg >= root_try)
                    begin
                        r0_next = r0_reg - root_try;
                        r1_next = (r1_reg >> 1) + r2_reg;
                    end
                    else
                    begin
                        r1_next = r1_reg >> 1;
                    end
                    r2_next = r2_reg >> 2;
                end
                default:
                begin
                    r1_next = r1_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ARITH_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;
    end
endmodule
`default_nettype wire

// File: design/twsc_back.sv
`default_nettype none
module twsc_back #(
    parameter int WINDOW_SAMPLES   = 1024,
    parameter int WINDOWS_PER_HOUR = 6,
    parameter int HOURS_PER_DAY    = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  twsc_pkg::item_t                 item,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  logic [twsc_pkg::LIMIT_W-1:0]    window_limit_seconds,
    output twsc_pkg::result_t               result,
    output logic                            result_push,
    input  logic                            result_full
);
    import twsc_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
    localparam int HN_W   = $clog2(WINDOWS_PER_HOUR + 1);
    localparam int DN_W   = $clog2(HOURS_PER_DAY + 1);
    localparam int NW_A   = (CNT_W > HN_W) ? CNT_W : HN_W;
    localparam int NW     = (NW_A > DN_W) ? NW_A : DN_W;
    localparam int AW     = 2 * NW + 2 * VAL_W;
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int SQ_W   = SQV_W + CNT_W;
    localparam int HSUM_W = VAL_W + HN_W;
    localparam int HSQ_W  = SQV_W + HN_W;
    localparam int DSUM_W = VAL_W + DN_W;
    localparam int DSQ_W  = SQV_W + DN_W;

    typedef enum logic [10:0] {
        B_IDLE = 11'b00000000001,
        B_UPD  = 11'b00000000010,
        B_CHK  = 11'b00000000100,
        B_MEAN = 11'b00000001000,
        B_MUL1 = 11'b00000010000,
        B_MUL2 = 11'b00000100000,
        B_MUL3 = 11'b00001000000,
        B_VAR  = 11'b00010000000,
        B_SQRT = 11'b00100000000,
        B_EMIT = 11'b01000000000,
        B_ACC  = 11'b10000000000
    } bstate_t;

    // Elapsed seconds from window start, modulo one day
    function automatic logic [DIFF_W-1:0] day_diff(input logic [SOD_W-1:0] now_s,
                                                   input logic [SOD_W-1:0] start_s);
        logic [DIFF_W-1:0] d;
        d = DIFF_W'(now_s) + TWO_DAYS - DIFF_W'(start_s);
        if (d >= DAY_SECONDS)
        begin
            d = d - DAY_SECONDS;
        end
        if (d >= DAY_SECONDS)
        begin
            d = d - DAY_SECONDS;
        end
        if (d >= DAY_SECONDS)
        begin
            d = d - DAY_SECONDS;
        end
        return d;
    endfunction

    bstate_t state_reg, state_next;
    item_t   cur_reg, cur_next;
    logic    issued_reg, issued_next;

    // Open window
    logic [CNT_W-1:0]  wcount_reg, wcount_next;
    logic [HOUR_W-1:0] wst_hour_reg, wst_hour_next;
    logic [MIN_W-1:0]  wst_min_reg, wst_min_next;
    logic [SEC_W-1:0]  wst_sec_reg, wst_sec_next;
    logic [SOD_W-1:0]  wst_s_reg, wst_s_next;
    logic [SUM_W-1:0]  wsum_reg, wsum_next;
    logic [SQ_W-1:0]   wsq_reg, wsq_next;
    logic [VAL_W-1:0]  wmax_reg, wmax_next;
    logic [VAL_W-1:0]  wmin_reg, wmin_next;

    // Hourly and daily sets
    logic [HSUM_W-1:0] hsum_reg, hsum_next;
    logic [HSQ_W-1:0]  hsq_reg, hsq_next;
    logic [VAL_W-1:0]  hmax_reg, hmax_next;
    logic [VAL_W-1:0]  hmin_reg, hmin_next;
    logic [DSUM_W-1:0] dsum_reg, dsum_next;
    logic [DSQ_W-1:0]  dsq_reg, dsq_next;
    logic [VAL_W-1:0]  dmax_reg, dmax_next;
    logic [VAL_W-1:0]  dmin_reg, dmin_next;
    logic [HN_W-1:0]   lc0_reg, lc0_next;
    logic [DN_W-1:0]   lc1_reg, lc1_next;

    // Statistics operands and intermediates
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [AW-1:0]      s1_reg, s1_next;
    logic [AW-1:0]      s2_reg, s2_next;
    logic [VAL_W-1:0]   smax_reg, smax_next;
    logic [VAL_W-1:0]   smin_reg, smin_next;
    logic [HOUR_W-1:0]  st_hour_reg, st_hour_next;
    logic [MIN_W-1:0]   st_min_reg, st_min_next;
    logic [SEC_W-1:0]   st_sec_reg, st_sec_next;
    logic [VAL_W-1:0]   mean_reg, mean_next;
    logic [AW-1:0]      t_reg, t_next;
    logic [AW-1:0]      nn_reg, nn_next;
    logic [VAL_W-1:0]   sd_reg, sd_next;

    arith_req_t    areq;
    arith_stat_t   astat;
    logic [AW-1:0] aa;
    logic [AW-1:0] ab;
    logic [AW-1:0] ay;

    logic              wfirst;
    logic              close;
    logic              hour_roll;
    logic              day_roll;
    logic [SQV_W-1:0]  msq;
    logic [HSUM_W-1:0] hsum_new;
    logic [HSQ_W-1:0]  hsq_new;
    logic [VAL_W-1:0]  hmax_new;
    logic [VAL_W-1:0]  hmin_new;
    logic [DSUM_W-1:0] dsum_new;
    logic [DSQ_W-1:0]  dsq_new;
    logic [VAL_W-1:0]  dmax_new;
    logic [VAL_W-1:0]  dmin_new;

    twsc_arith #(
        .AW (AW)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .a     (aa),
        .b     (ab),
        .stat  (astat),
        .y     (ay)
    );

    assign wfirst    = (wcount_reg == '0);
    assign close     = (day_diff(cur_reg.now_s, wst_s_reg) >= DIFF_W'(window_limit_seconds))
                    || cur_reg.boundary_hit;
    assign hour_roll = (lc0_reg == HN_W'(WINDOWS_PER_HOUR - 1));
    assign day_roll  = (lc1_reg == DN_W'(HOURS_PER_DAY - 1));

    // Fold a finished mean into the next level's set
    assign msq      = SQV_W'(mean_reg) * SQV_W'(mean_reg);
    assign hsum_new = ((lc0_reg == '0) ? '0 : hsum_reg) + HSUM_W'(mean_reg);
    assign hsq_new  = ((lc0_reg == '0) ? '0 : hsq_reg) + HSQ_W'(msq);
    assign hmax_new = ((lc0_reg == '0) || (mean_reg > hmax_reg)) ? mean_reg : hmax_reg;
    assign hmin_new = ((lc0_reg == '0) || (mean_reg < hmin_reg)) ? mean_reg : hmin_reg;
    assign dsum_new = ((lc1_reg == '0) ? '0 : dsum_reg) + DSUM_W'(mean_reg);
    assign dsq_new  = ((lc1_reg == '0) ? '0 : dsq_reg) + DSQ_W'(msq);
    assign dmax_new = ((lc1_reg == '0) || (mean_reg > dmax_reg)) ? mean_reg : dmax_reg;
    assign dmin_new = ((lc1_reg == '0) || (mean_reg < dmin_reg)) ? mean_reg : dmin_reg;

    // Result beat
    always_comb
    begin
        result.level  = level_reg;
        result.mean   = mean_reg;
        result.maxv   = smax_reg;
        result.minv   = smin_reg;
        result.sd     = sd_reg;
        result.count  = CNT_OUT_W'(n_reg);
        result.hour   = st_hour_reg;
        result.minute = st_min_reg;
        result.second = st_sec_reg;
        case (level_reg)
            LVL_WINDOW: result.last = !hour_roll;
            LVL_HOUR:   result.last = !day_roll;
            default:    result.last = 1'b1;
        endcase
    end

    // Arithmetic operand select
    always_comb
    begin
        aa      = s1_reg;
        ab      = AW'(n_reg);
        areq.op = ARITH_DIV;
        unique case (state_reg)
            B_MUL1:
            begin
                aa      = s2_reg;
                ab      = AW'(n_reg);
                areq.op = ARITH_MUL;
            end
            B_MUL2:
            begin
                aa      = s1_reg;
                ab      = s1_reg;
                areq.op = ARITH_MUL;
            end
            B_MUL3:
            begin
                aa      = AW'(n_reg);
                ab      = AW'(n_reg);
                areq.op = ARITH_MUL;
            end
            B_VAR:
            begin
                aa      = t_reg;
                ab      = nn_reg;
                areq.op = ARITH_DIV;
            end
            B_SQRT:
            begin
                aa      = t_reg;
                ab      = nn_reg;
                areq.op = ARITH_SQRT;
            end
            default:
            begin
                areq.op = ARITH_DIV;
            end
        endcase
    end

    // Engine sequence
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        issued_next   = issued_reg;
        wcount_next   = wcount_reg;
        wst_hour_next = wst_hour_reg;
        wst_min_next  = wst_min_reg;
        wst_sec_next  = wst_sec_reg;
        wst_s_next    = wst_s_reg;
        wsum_next     = wsum_reg;
        wsq_next      = wsq_reg;
        wmax_next     = wmax_reg;
        wmin_next     = wmin_reg;
        hsum_next     = hsum_reg;
        hsq_next      = hsq_reg;
        hmax_next     = hmax_reg;
        hmin_next     = hmin_reg;
        dsum_next     = dsum_reg;
        dsq_next      = dsq_reg;
        dmax_next     = dmax_reg;
        dmin_next     = dmin_reg;
        lc0_next      = lc0_reg;
        lc1_next      = lc1_reg;
        level_next    = level_reg;
        n_next        = n_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        smax_next     = smax_reg;
        smin_next     = smin_reg;
        st_hour_next  = st_hour_reg;
        st_min_next   = st_min_reg;
        st_sec_next   = st_sec_reg;
        mean_next     = mean_reg;
        t_next        = t_reg;
        nn_next       = nn_reg;
        sd_next       = sd_reg;
        item_pop      = 1'b0;
        result_push   = 1'b0;
        areq.start    = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    cur_next   = item;
                    item_pop   = 1'b1;
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                if (wfirst)
                begin
                    wst_hour_next = cur_reg.hour;
                    wst_min_next  = cur_reg.minute;
                    wst_sec_next  = cur_reg.second;
                    wst_s_next    = cur_reg.now_s;
                end
                // Drop the sample once the window is full
                if (wcount_reg < CNT_W'(WINDOW_SAMPLES))
                begin
                    wsum_next   = (wfirst ? '0 : wsum_reg) + SUM_W'(cur_reg.sample);
                    wsq_next    = (wfirst ? '0 : wsq_reg) + SQ_W'(cur_reg.sq);
                    wmax_next   = (wfirst || (cur_reg.sample > wmax_reg)) ? cur_reg.sample
                                                                          : wmax_reg;
                    wmin_next   = (wfirst || (cur_reg.sample < wmin_reg)) ? cur_reg.sample
                                                                          : wmin_reg;
                    wcount_next = wcount_reg + 1'b1;
                end
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (close)
                begin
                    level_next   = LVL_WINDOW;
                    n_next       = NW'(wcount_reg);
                    s1_next      = AW'(wsum_reg);
                    s2_next      = AW'(wsq_reg);
                    smax_next    = wmax_reg;
                    smin_next    = wmin_reg;
                    st_hour_next = wst_hour_reg;
                    st_min_next  = wst_min_reg;
                    st_sec_next  = wst_sec_reg;
                    wcount_next  = '0;
                    state_next   = B_MEAN;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_MEAN, B_MUL1, B_MUL2, B_MUL3, B_VAR, B_SQRT:
            begin
                areq.start  = !issued_reg;
                issued_next = 1'b1;
                if (astat.done)
                begin
                    issued_next = 1'b0;
                    unique case (state_reg)
                        B_MEAN:
                        begin
                            mean_next  = ay[VAL_W-1:0];
                            state_next = B_MUL1;
                        end
                        B_MUL1:
                        begin
                            t_next     = ay;
                            state_next = B_MUL2;
                        end
                        B_MUL2:
                        begin
                            t_next     = (t_reg >= ay) ? (t_reg - ay) : '0;
                            state_next = B_MUL3;
                        end
                        B_MUL3:
                        begin
                            nn_next    = ay;
                            state_next = B_VAR;
                        end
                        B_VAR:
                        begin
                            t_next     = ay;
                            state_next = B_SQRT;
                        end
                        default:
                        begin
                            sd_next    = ay[VAL_W-1:0];
                            state_next = B_EMIT;
                        end
                    endcase
                end
            end
            B_EMIT:
            begin
                if (!result_full)
                begin
                    result_push = 1'b1;
                    state_next  = (level_reg == LVL_DAY) ? B_IDLE : B_ACC;
                end
            end
            B_ACC:
            begin
                st_hour_next = cur_reg.hour;
                st_min_next  = cur_reg.minute;
                st_sec_next  = cur_reg.second;
                if (level_reg == LVL_WINDOW)
                begin
                    hsum_next  = hsum_new;
                    hsq_next   = hsq_new;
                    hmax_next  = hmax_new;
                    hmin_next  = hmin_new;
                    lc0_next   = hour_roll ? '0 : (lc0_reg + 1'b1);
                    level_next = LVL_HOUR;
                    n_next     = NW'(WINDOWS_PER_HOUR);
                    s1_next    = AW'(hsum_new);
                    s2_next    = AW'(hsq_new);
                    smax_next  = hmax_new;
                    smin_next  = hmin_new;
                    state_next = hour_roll ? B_MEAN : B_IDLE;
                end
                else
                begin
                    dsum_next  = dsum_new;
                    dsq_next   = dsq_new;
                    dmax_next  = dmax_new;
                    dmin_next  = dmin_new;
                    lc1_next   = day_roll ? '0 : (lc1_reg + 1'b1);
                    level_next = LVL_DAY;
                    n_next     = NW'(HOURS_PER_DAY);
                    s1_next    = AW'(dsum_new);
                    s2_next    = AW'(dsq_new);
                    smax_next  = dmax_new;
                    smin_next  = dmin_new;
                    state_next = day_roll ? B_MEAN : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            issued_reg <= 1'b0;
            wcount_reg <= '0;
            lc0_reg    <= '0;
            lc1_reg    <= '0;
            level_reg  <= LVL_WINDOW;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            wcount_reg <= wcount_next;
            lc0_reg    <= lc0_next;
            lc1_reg    <= lc1_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        wst_hour_reg <= wst_hour_next;
        wst_min_reg  <= wst_min_next;
        wst_sec_reg  <= wst_sec_next;
        wst_s_reg    <= wst_s_next;
        wsum_reg     <= wsum_next;
        wsq_reg      <= wsq_next;
        wmax_reg     <= wmax_next;
        wmin_reg     <= wmin_next;
        hsum_reg     <= hsum_next;
        hsq_reg      <= hsq_next;
        hmax_reg     <= hmax_next;
        hmin_reg     <= hmin_next;
        dsum_reg     <= dsum_next;
        dsq_reg      <= dsq_next;
        dmax_reg     <= dmax_next;
        dmin_reg     <= dmin_next;
        n_reg        <= n_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        smax_reg     <= smax_next;
        smin_reg     <= smin_next;
        st_hour_reg  <= st_hour_next;
        st_min_reg   <= st_min_next;
        st_sec_reg   <= st_sec_next;
        mean_reg     <= mean_next;
        t_reg        <= t_next;
        nn_reg       <= nn_next;
        sd_reg       <= sd_next;
    end
endmodule
`default_nettype wire

// File: design/timed_window_stats_cascade_unit.sv
// Channel   Direction  Handshake           Beat
// input     in         push / full         sample, hour_of_day, minute_of_hour, second_of_minute
// result    out        empty / pop         level, mean_value .. stamp_second, last
// config    in         wr_en (no wait)     wr_index, wr_data
//
// Front takes a sample through capture, six minute-modulo steps and a queue write that
// waits while the middle queue is full; full stays high until that write. Back passes a
// sample that closes nothing through update and check states; each emitted statistic runs
// two divides, three multiplies, one square root on the shared bit-serial unit (AW = 2*count
// width + 36). Reset is asynchronous; there is no clearing pass. A full result queue stalls
// the back end only; the front keeps accepting until the two-entry middle queue fills.
`default_nettype none
module timed_window_stats_cascade_unit #(
    parameter int WINDOW_SAMPLES   = 1024,
    parameter int WINDOWS_PER_HOUR = 6,
    parameter int HOURS_PER_DAY    = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [twsc_pkg::VAL_W-1:0]       sample,
    input  logic [twsc_pkg::HOUR_W-1:0]      hour_of_day,
    input  logic [twsc_pkg::MIN_W-1:0]       minute_of_hour,
    input  logic [twsc_pkg::SEC_W-1:0]       second_of_minute,
    output logic                             empty,
    input  logic                             pop,
    output logic [twsc_pkg::LEVEL_W-1:0]     level,
    output logic [twsc_pkg::VAL_W-1:0]       mean_value,
    output logic [twsc_pkg::VAL_W-1:0]       max_value,
    output logic [twsc_pkg::VAL_W-1:0]       min_value,
    output logic [twsc_pkg::VAL_W-1:0]       std_dev,
    output logic [twsc_pkg::CNT_OUT_W-1:0]   sample_count,
    output logic [twsc_pkg::HOUR_W-1:0]      stamp_hour,
    output logic [twsc_pkg::MIN_W-1:0]       stamp_minute,
    output logic [twsc_pkg::SEC_W-1:0]       stamp_second,
    output logic                             last,
    input  logic                             wr_en,
    input  logic [twsc_pkg::IDX_W-1:0]       wr_index,
    input  logic [twsc_pkg::LIMIT_W-1:0]     wr_data
);
    import twsc_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [BND_W-1:0]   boundary_reg;

    item_t   fr_item;
    logic    fr_valid;
    logic    mid_full;
    item_t   mid_item;
    logic    mid_empty;
    logic    mid_pop;
    result_t bk_result;
    logic    bk_push;
    logic    res_full;
    result_t res_head;

    // Configuration registers; other indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            boundary_reg <= BOUNDARY_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_LIMIT:    limit_reg    <= wr_data;
                REG_BOUNDARY: boundary_reg <= wr_data[BND_W-1:0];
                default:      limit_reg    <= limit_reg;
            endcase
        end
    end

    twsc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .sample           (sample),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .full             (full),
        .boundary_minutes (boundary_reg),
        .item             (fr_item),
        .item_valid       (fr_valid),
        .item_ready       (!mid_full)
    );

    twsc_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .din   (fr_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_item),
        .empty (mid_empty)
    );

    twsc_back #(
        .WINDOW_SAMPLES   (WINDOW_SAMPLES),
        .WINDOWS_PER_HOUR (WINDOWS_PER_HOUR),
        .HOURS_PER_DAY    (HOURS_PER_DAY)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item                 (mid_item),
        .item_valid           (!mid_empty),
        .item_pop             (mid_pop),
        .window_limit_seconds (limit_reg),
        .result               (bk_result),
        .result_push          (bk_push),
        .result_full          (res_full)
    );

    twsc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .din   (bk_result),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign level        = res_head.level;
    assign mean_value   = res_head.mean;
    assign max_value    = res_head.maxv;
    assign min_value    = res_head.minv;
    assign std_dev      = res_head.sd;
    assign sample_count = res_head.count;
    assign stamp_hour   = res_head.hour;
    assign stamp_minute = res_head.minute;
    assign stamp_second = res_head.second;
    assign last         = res_head.last;
endmodule
`default_nettype wire

// File: design/twsc_checker.sv
`default_nettype none
`include "timed_window_stats_cascade_unit_defines.svh"
module twsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic [twsc_pkg::LEVEL_W-1:0]   level,
    input logic [twsc_pkg::VAL_W-1:0]     mean_value,
    input logic [twsc_pkg::VAL_W-1:0]     max_value,
    input logic [twsc_pkg::VAL_W-1:0]     min_value,
    input logic [twsc_pkg::VAL_W-1:0]     std_dev
);
    // Hold a stalled result beat
    `TWSC_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(mean_value) && $stable(level))
    // Extremes are ordered
    `TWSC_ASSERT_HOLDS(a_extremes, empty || (max_value >= min_value))
    // Mean lies between the extremes
    `TWSC_ASSERT_HOLDS(a_mean_range, empty || ((mean_value <= max_value) && (mean_value >= min_value)))
    // Deviation never exceeds the spread
    `TWSC_ASSERT_HOLDS(a_std_range, empty || (std_dev <= (max_value - min_value)))
endmodule

bind timed_window_stats_cascade_unit twsc_checker u_twsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .level      (level),
    .mean_value (mean_value),
    .max_value  (max_value),
    .min_value  (min_value),
    .std_dev    (std_dev)
);
`default_nettype wire
